// ===== rtl/core/note_hold_timer_table_defines.svh =====
// Assertion helpers for the note hold timer table checker.
// Each one samples on the rising edge of clk and is off while arst_n is low.
`ifndef NOTE_HOLD_TIMER_TABLE_DEFINES_SVH
`define NOTE_HOLD_TIMER_TABLE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define NHT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nht: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define NHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nht: next-cycle check failed");

`endif

// ===== rtl/core/nht_pkg.sv =====
`timescale 1ns / 1ps
package nht_pkg;

	localparam int SLOTS       = 16;
	localparam int WHITE_KEYS  = 52;
	localparam int BLACK_KEYS  = 36;
	localparam int MAX_RESULTS = 16;
	localparam int CAP         = (SLOTS < MAX_RESULTS) ? SLOTS : MAX_RESULTS;
	localparam int IDX_W       = $clog2(CAP);
	localparam int CNT_W       = $clog2(CAP + 1);
	localparam int HOLD_W      = 8;
	localparam int DIV_STEPS   = 8;
	localparam int SKIP_N      = 15;

	localparam logic [7:0] TPW_RESET = 8'd16;

	localparam logic EV_PRESS   = 1'b0;
	localparam logic EV_RELEASE = 1'b1;

	typedef logic [5:0] line_t;

	localparam line_t SKIP_LINES [SKIP_N] = '{
		6'd1, 6'd4, 6'd8, 6'd11, 6'd15, 6'd18, 6'd22, 6'd25,
		6'd29, 6'd32, 6'd36, 6'd39, 6'd43, 6'd46, 6'd50
	};

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_NOTE    = 2'd1,
		ACT_END_COL = 2'd2,
		ACT_FLUSH   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SRCH,
		ST_COL,
		ST_FLUSH
	} state_t;

	// Key position within its row; black keys skip the gaps in the skip list.
	function automatic logic [5:0] key_of(input line_t line, input logic black);
		logic [5:0] d;
		d = '0;
		for (int i = 0; i < SKIP_N; i++) begin
			if (line > SKIP_LINES[i])
				d = d + 6'd1;
		end
		if (black)
			return 6'(BLACK_KEYS - 1) - (line - d);
		else
			return 6'(WHITE_KEYS - 1) - line;
	endfunction

endpackage

// ===== rtl/core/note_hold_timer_table.sv =====
`timescale 1ns / 1ps
// Note hold timer table: keeps up to 16 sounding notes with their remaining ticks.
// Command channel: an item is taken at a rising edge with start high and busy low.
//   action 0 tick: every nonzero count drops by one; done in that cycle, busy stays low.
//   action 1 note: an 8-step restoring divider forms ticks_per_whole / note_value,
//     then the table is scanned one entry per cycle for the same line and colour.
//     One press result follows.
//   action 2 end of column: one entry per cycle, expired entries are released and
//     the rest are packed down.
//   action 3 flush: releases every entry, one per cycle.
// Results leave through a register: strobe is high for exactly one cycle per result,
// in the cycle after the scan step that found it; last marks the final one of an item.
// The receiver cannot stall, so results are never held back.
// The sequencer and its one-entry-per-cycle scan set the rate; the divider is shared
// by nothing else and runs once per note.
// cfg_we writes ticks_per_whole from cfg_data; write it only while busy is low.
// Reset empties the table, loads ticks_per_whole with 16 and clears busy and strobe.
module note_hold_timer_table (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [5:0] note_line,
	input  logic       note_is_black,
	input  logic [6:0] note_value,
	output logic       strobe,
	output logic       event_kind,
	output logic [5:0] key_index,
	output logic [5:0] key_line,
	output logic       key_is_black,
	output logic       table_full,
	output logic       last
);

	localparam int CAP   = nht_pkg::CAP;
	localparam int IDX_W = nht_pkg::IDX_W;
	localparam int CNT_W = nht_pkg::CNT_W;
	localparam int HW    = nht_pkg::HOLD_W;

	nht_pkg::state_t state_q, state_d;

	logic [7:0]       tpw_q;
	logic [CNT_W-1:0] idx_q, keep_q, count_q;
	logic [2:0]       step_q;
	logic [7:0]       acc_q, rem_q;
	logic [6:0]       dvs_q;
	logic [5:0]       line_q;
	logic             black_q;
	logic [CAP-1:0]   zmask_q;

	logic [5:0]       slot_line_q  [CAP];
	logic             slot_black_q [CAP];
	logic [HW-1:0]    slot_ticks_q [CAP];

	logic             strobe_q, event_kind_q, key_is_black_q, table_full_q, last_q;
	logic [5:0]       key_index_q, key_line_q;

	logic             accept;
	logic [IDX_W-1:0] idx, keep_idx;
	logic             at_end, match, flush_last, col_last;
	logic [5:0]       cur_line;
	logic             cur_black;
	logic [HW-1:0]    cur_ticks;
	logic [7:0]       rem_sh, rem_nx, acc_nx;
	logic             ge;

	logic             emit, emit_kind, emit_full, emit_last, from_slot;
	logic [5:0]       emit_line;
	logic             emit_black;

	assign accept   = start && !busy;
	assign busy     = (state_q != nht_pkg::ST_IDLE);
	assign idx      = idx_q[IDX_W-1:0];
	assign keep_idx = keep_q[IDX_W-1:0];
	assign at_end   = (idx_q == count_q);

	assign cur_line  = slot_line_q[idx];
	assign cur_black = slot_black_q[idx];
	assign cur_ticks = slot_ticks_q[idx];

	assign match      = (cur_line == line_q) && (cur_black == black_q);
	assign flush_last = (CNT_W'(idx_q + 1'b1) == count_q);
	// Release is final when no expired entry sits above this one.
	assign col_last   = ~|((zmask_q >> idx) >> 1);

	// One restoring divide step per cycle.
	assign rem_sh = {rem_q[6:0], acc_q[7]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	assign acc_nx = {acc_q[6:0], ge};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nht_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (nht_pkg::action_t'(action))
						nht_pkg::ACT_TICK:    state_d = nht_pkg::ST_IDLE;
						nht_pkg::ACT_NOTE:    state_d = nht_pkg::ST_DIV;
						nht_pkg::ACT_END_COL: state_d = nht_pkg::ST_COL;
						nht_pkg::ACT_FLUSH:   state_d = nht_pkg::ST_FLUSH;
						default:              state_d = nht_pkg::ST_IDLE;
					endcase
				end
			end
			nht_pkg::ST_DIV: begin
				if (step_q == 3'(nht_pkg::DIV_STEPS - 1))
					state_d = nht_pkg::ST_SRCH;
			end
			nht_pkg::ST_SRCH: begin
				if (at_end || match)
					state_d = nht_pkg::ST_IDLE;
			end
			nht_pkg::ST_COL: begin
				if (at_end)
					state_d = nht_pkg::ST_IDLE;
			end
			nht_pkg::ST_FLUSH: begin
				if (at_end || flush_last)
					state_d = nht_pkg::ST_IDLE;
			end
			default: state_d = nht_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_kind = nht_pkg::EV_PRESS;
		emit_full = 1'b0;
		emit_last = 1'b0;
		from_slot = 1'b0;
		unique case (state_q)
			nht_pkg::ST_SRCH: begin
				emit      = at_end || match;
				emit_full = at_end && (count_q == CNT_W'(CAP));
				emit_last = 1'b1;
			end
			nht_pkg::ST_COL: begin
				emit      = !at_end && (cur_ticks == '0);
				emit_kind = nht_pkg::EV_RELEASE;
				emit_last = col_last;
				from_slot = 1'b1;
			end
			nht_pkg::ST_FLUSH: begin
				emit      = !at_end;
				emit_kind = nht_pkg::EV_RELEASE;
				emit_last = flush_last;
				from_slot = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign emit_line  = from_slot ? cur_line : line_q;
	assign emit_black = from_slot ? cur_black : black_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= nht_pkg::ST_IDLE;
			tpw_q    <= nht_pkg::TPW_RESET;
			idx_q    <= '0;
			keep_q   <= '0;
			count_q  <= '0;
			step_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (cfg_we)
				tpw_q <= cfg_data;
			unique case (state_q)
				nht_pkg::ST_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						keep_q <= '0;
						step_q <= '0;
					end
				end
				nht_pkg::ST_DIV: begin
					step_q <= step_q + 3'd1;
				end
				nht_pkg::ST_SRCH: begin
					if (at_end) begin
						if (count_q != CNT_W'(CAP))
							count_q <= count_q + 1'b1;
					end else if (!match) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				nht_pkg::ST_COL: begin
					if (at_end) begin
						count_q <= keep_q;
					end else begin
						idx_q <= idx_q + 1'b1;
						if (cur_ticks != '0)
							keep_q <= keep_q + 1'b1;
					end
				end
				nht_pkg::ST_FLUSH: begin
					if (!at_end)
						idx_q <= idx_q + 1'b1;
					if (state_d == nht_pkg::ST_IDLE)
						count_q <= '0;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			event_kind_q   <= emit_kind;
			key_index_q    <= nht_pkg::key_of(emit_line, emit_black);
			key_line_q     <= emit_line;
			key_is_black_q <= emit_black;
			table_full_q   <= emit_full;
			last_q         <= emit_last;
		end
		unique case (state_q)
			nht_pkg::ST_IDLE: begin
				if (accept) begin
					line_q  <= note_line;
					black_q <= note_is_black;
					acc_q   <= tpw_q;
					rem_q   <= '0;
					dvs_q   <= (note_value == '0) ? 7'd1 : note_value;
					for (int j = 0; j < CAP; j++)
						zmask_q[j] <= (slot_ticks_q[j] == '0) && (CNT_W'(j) < count_q);
					if (action == nht_pkg::ACT_TICK) begin
						for (int j = 0; j < CAP; j++) begin
							if (slot_ticks_q[j] != '0)
								slot_ticks_q[j] <= slot_ticks_q[j] - 1'b1;
						end
					end
				end
			end
			nht_pkg::ST_DIV: begin
				acc_q <= acc_nx;
				rem_q <= rem_nx;
			end
			nht_pkg::ST_SRCH: begin
				// On a hit reload the count; at the end append if there is room.
				if (!at_end && match) begin
					slot_ticks_q[idx] <= acc_q;
				end else if (at_end && (count_q != CNT_W'(CAP))) begin
					slot_line_q[idx]  <= line_q;
					slot_black_q[idx] <= black_q;
					slot_ticks_q[idx] <= acc_q;
				end
			end
			nht_pkg::ST_COL: begin
				// Pack surviving entries down to the keep pointer.
				if (!at_end && (cur_ticks != '0)) begin
					slot_line_q[keep_idx]  <= cur_line;
					slot_black_q[keep_idx] <= cur_black;
					slot_ticks_q[keep_idx] <= cur_ticks;
				end
			end
			default: begin
				line_q <= line_q;
			end
		endcase
	end

	assign strobe       = strobe_q;
	assign event_kind   = event_kind_q;
	assign key_index    = key_index_q;
	assign key_line     = key_line_q;
	assign key_is_black = key_is_black_q;
	assign table_full   = table_full_q;
	assign last         = last_q;

endmodule

// ===== rtl/core/nht_checker.sv =====
`timescale 1ns / 1ps
`include "note_hold_timer_table_defines.svh"
module nht_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic [7:0] cfg_data,
	input logic       start,
	input logic       busy,
	input logic [1:0] action,
	input logic [5:0] note_line,
	input logic       note_is_black,
	input logic [6:0] note_value,
	input logic       strobe,
	input logic       event_kind,
	input logic [5:0] key_index,
	input logic [5:0] key_line,
	input logic       key_is_black,
	input logic       table_full,
	input logic       last
);

	// A full-table flag only ever rides on a press.
	`NHT_ASSERT_SAME(a_full_on_press, strobe && table_full, event_kind == nht_pkg::EV_PRESS)
	// A press is the only result of its transaction.
	`NHT_ASSERT_SAME(a_press_last, strobe && (event_kind == nht_pkg::EV_PRESS), last)
	// An accepted note transaction sets busy.
	`NHT_ASSERT_NEXT(a_note_busy, start && !busy && (action == nht_pkg::ACT_NOTE), busy)
	// A tick completes in its own cycle.
	`NHT_ASSERT_NEXT(a_tick_free, start && !busy && (action == nht_pkg::ACT_TICK), !busy)
	// A tick never causes a result.
	`NHT_ASSERT_NEXT(a_tick_quiet, start && !busy && (action == nht_pkg::ACT_TICK), !strobe)

endmodule

bind note_hold_timer_table nht_checker u_nht_checker (.*);
